>>> rtl/lid_pkg.sv
// Shared constants for the two-line intersection block.
// No dependencies; used by every other file of the block except lid_div_stage.
package lid_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int UA_FRAC         = 32;
  localparam int TOL_WIDTH       = 31;

endpackage

>>> rtl/lid_if.sv
// Request channels of the intersection block: point sets in, intersections out.
// Depends on lid_pkg for the default coordinate width.
interface lid_pts_if #(
  parameter int COORD_WIDTH = lid_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_start_x;
  logic signed [COORD_WIDTH-1:0] a_start_y;
  logic signed [COORD_WIDTH-1:0] a_end_x;
  logic signed [COORD_WIDTH-1:0] a_end_y;
  logic signed [COORD_WIDTH-1:0] b_start_x;
  logic signed [COORD_WIDTH-1:0] b_start_y;
  logic signed [COORD_WIDTH-1:0] b_end_x;
  logic signed [COORD_WIDTH-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface lid_isect_if #(
  parameter int COORD_WIDTH = lid_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] cross_x;
  logic signed [COORD_WIDTH-1:0] cross_y;

  modport source (output valid, cross_x, cross_y, input ready);
  modport sink   (input valid, cross_x, cross_y, output ready);
endinterface

>>> rtl/lid_front.sv
// Front stages: differences, cross products, denominator and numerator,
// magnitudes and tolerance clamp. Depends on lid_pkg.
module lid_front #(
  parameter int COORD_WIDTH = lid_pkg::COORD_WIDTH_DEF,
  localparam int DW = COORD_WIDTH + 1,
  localparam int PW = 2 * DW,
  localparam int SW = PW + 1,
  localparam int NW = SW + lid_pkg::UA_FRAC
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic [lid_pkg::TOL_WIDTH-1:0]        tol,
  input  logic                                 in_valid,
  input  logic signed [COORD_WIDTH-1:0]        ax0,
  input  logic signed [COORD_WIDTH-1:0]        ay0,
  input  logic signed [COORD_WIDTH-1:0]        ax1,
  input  logic signed [COORD_WIDTH-1:0]        ay1,
  input  logic signed [COORD_WIDTH-1:0]        bx0,
  input  logic signed [COORD_WIDTH-1:0]        by0,
  input  logic signed [COORD_WIDTH-1:0]        bx1,
  input  logic signed [COORD_WIDTH-1:0]        by1,
  output logic                                 out_valid,
  output logic [SW-1:0]                        d_mag,
  output logic [NW-1:0]                        dividend,
  output logic                                 q_neg,
  output logic signed [DW-1:0]                 o_dax,
  output logic signed [DW-1:0]                 o_day,
  output logic signed [COORD_WIDTH-1:0]        o_ax0,
  output logic signed [COORD_WIDTH-1:0]        o_ay0
);

  logic                          v1, v2, v3, v4;
  logic signed [DW-1:0]          dax1, day1, dbx1, dby1, ox1, oy1;
  logic signed [COORD_WIDTH-1:0] ax0_1, ay0_1, ax0_2, ay0_2, ax0_3, ay0_3, ax0_4, ay0_4;
  logic signed [DW-1:0]          dax2, day2, dax3, day3, dax4, day4;
  logic signed [PW-1:0]          p0, p1, p2, p3;
  logic signed [SW-1:0]          den, num;
  logic [SW-1:0]                 den_mag, num_mag, tol_ext;
  logic                          den_neg, den_pos, num_neg, below_tol, d_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  assign tol_ext   = (tol == '0) ? SW'(1) : SW'(tol);
  assign below_tol = den_mag < tol_ext;
  assign d_neg     = below_tol ? !den_pos : den_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      dax1  <= $signed({ax1[COORD_WIDTH-1], ax1}) - $signed({ax0[COORD_WIDTH-1], ax0});
      day1  <= $signed({ay1[COORD_WIDTH-1], ay1}) - $signed({ay0[COORD_WIDTH-1], ay0});
      dbx1  <= $signed({bx1[COORD_WIDTH-1], bx1}) - $signed({bx0[COORD_WIDTH-1], bx0});
      dby1  <= $signed({by1[COORD_WIDTH-1], by1}) - $signed({by0[COORD_WIDTH-1], by0});
      ox1   <= $signed({ax0[COORD_WIDTH-1], ax0}) - $signed({bx0[COORD_WIDTH-1], bx0});
      oy1   <= $signed({ay0[COORD_WIDTH-1], ay0}) - $signed({by0[COORD_WIDTH-1], by0});
      ax0_1 <= ax0;
      ay0_1 <= ay0;

      p0    <= dby1 * dax1;
      p1    <= dbx1 * day1;
      p2    <= dbx1 * oy1;
      p3    <= dby1 * ox1;
      dax2  <= dax1;
      day2  <= day1;
      ax0_2 <= ax0_1;
      ay0_2 <= ay0_1;

      den   <= $signed({p0[PW-1], p0}) - $signed({p1[PW-1], p1});
      num   <= $signed({p2[PW-1], p2}) - $signed({p3[PW-1], p3});
      dax3  <= dax2;
      day3  <= day2;
      ax0_3 <= ax0_2;
      ay0_3 <= ay0_2;

      den_mag <= den[SW-1] ? SW'(-den) : SW'(den);
      num_mag <= num[SW-1] ? SW'(-num) : SW'(num);
      den_neg <= den[SW-1];
      den_pos <= !den[SW-1] && (den != '0);
      num_neg <= num[SW-1];
      dax4  <= dax3;
      day4  <= day3;
      ax0_4 <= ax0_3;
      ay0_4 <= ay0_3;

      d_mag    <= below_tol ? tol_ext : den_mag;
      dividend <= {num_mag, {lid_pkg::UA_FRAC{1'b0}}};
      q_neg    <= num_neg ^ d_neg;
      o_dax    <= dax4;
      o_day    <= day4;
      o_ax0    <= ax0_4;
      o_ay0    <= ay0_4;
    end
  end

endmodule

>>> rtl/lid_div_stage.sv
// One restoring division step: one quotient bit per stage.
// Depends on nothing; instantiated in a chain by the top level.
module lid_div_stage #(
  parameter int MW     = 67,
  parameter int NW     = 99,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [MW-1:0]     in_rem,
  input  logic [NW-1:0]     in_nq,
  input  logic [MW-1:0]     in_d,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [MW-1:0]     out_rem,
  output logic [NW-1:0]     out_nq,
  output logic [MW-1:0]     out_d,
  output logic [SIDE_W-1:0] out_side
);

  logic [MW:0] trial, diff;
  logic        ge;

  assign trial = {in_rem, in_nq[NW-1]};
  assign diff  = trial - {1'b0, in_d};
  assign ge    = trial >= {1'b0, in_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= ge ? diff[MW-1:0] : trial[MW-1:0];
      out_nq   <= {in_nq[NW-2:0], ge};
      out_d    <= in_d;
      out_side <= in_side;
    end
  end

endmodule

>>> rtl/lid_back.sv
// Back stages: ua times the line-one direction in partial products,
// shift, offset by the start point and saturate. Depends on lid_pkg.
module lid_back #(
  parameter int COORD_WIDTH = lid_pkg::COORD_WIDTH_DEF,
  localparam int DW  = COORD_WIDTH + 1,
  localparam int NW  = 2 * DW + 1 + lid_pkg::UA_FRAC,
  localparam int K   = (NW + DW - 1) / DW,
  localparam int PRW = K * DW + DW,
  localparam int SHW = PRW - lid_pkg::UA_FRAC,
  localparam int RW  = SHW + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [NW-1:0]                 ua,
  input  logic                          q_neg,
  input  logic signed [DW-1:0]          dax,
  input  logic signed [DW-1:0]          day,
  input  logic signed [COORD_WIDTH-1:0] ax0,
  input  logic signed [COORD_WIDTH-1:0] ay0,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] cx,
  output logic signed [COORD_WIDTH-1:0] cy
);

  localparam logic signed [RW-1:0] RMAX = {{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RW-1:0] RMIN = {{(RW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic                          v1, v2, v3, v4;
  logic [K*DW-1:0]               ua1;
  logic [DW-1:0]                 xm1, ym1;
  logic                          xn1, yn1, xn2, yn2, xn3, yn3;
  logic signed [COORD_WIDTH-1:0] ax1, ay1, ax2, ay2, ax3, ay3;
  logic [2*DW-1:0]               ppx [K];
  logic [2*DW-1:0]               ppy [K];
  logic [PRW-1:0]                sumx, sumy;
  logic [SHW-1:0]                mx, my;
  logic signed [RW-1:0]          rx, ry, ax3e, ay3e, mxe, mye;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_comb begin
    sumx = '0;
    sumy = '0;
    for (int k = 0; k < K; k++) begin
      sumx = sumx + (PRW'(ppx[k]) << (k * DW));
      sumy = sumy + (PRW'(ppy[k]) << (k * DW));
    end
  end

  assign ax3e = RW'(ax3);
  assign ay3e = RW'(ay3);
  assign mxe  = $signed(RW'(mx));
  assign mye  = $signed(RW'(my));

  always_ff @(posedge clk) begin
    if (en) begin
      ua1 <= (K*DW)'(ua);
      xm1 <= dax[DW-1] ? DW'(-dax) : DW'(dax);
      ym1 <= day[DW-1] ? DW'(-day) : DW'(day);
      xn1 <= q_neg ^ dax[DW-1];
      yn1 <= q_neg ^ day[DW-1];
      ax1 <= ax0;
      ay1 <= ay0;

      for (int k = 0; k < K; k++) begin
        ppx[k] <= ua1[k*DW +: DW] * xm1;
        ppy[k] <= ua1[k*DW +: DW] * ym1;
      end
      xn2 <= xn1;
      yn2 <= yn1;
      ax2 <= ax1;
      ay2 <= ay1;

      mx  <= sumx[PRW-1:lid_pkg::UA_FRAC];
      my  <= sumy[PRW-1:lid_pkg::UA_FRAC];
      xn3 <= xn2;
      yn3 <= yn2;
      ax3 <= ax2;
      ay3 <= ay2;

      rx <= xn3 ? ax3e - mxe : ax3e + mxe;
      ry <= yn3 ? ay3e - mye : ay3e + mye;

      cx <= (rx > RMAX) ? RMAX[COORD_WIDTH-1:0] :
            (rx < RMIN) ? RMIN[COORD_WIDTH-1:0] : rx[COORD_WIDTH-1:0];
      cy <= (ry > RMAX) ? RMAX[COORD_WIDTH-1:0] :
            (ry < RMIN) ? RMIN[COORD_WIDTH-1:0] : ry[COORD_WIDTH-1:0];
    end
  end

endmodule

>>> rtl/line_intersection_2d.sv
// Top level of the two-line intersection block.
// Depends on lid_pkg, lid_if, lid_front, lid_div_stage and lid_back.
//
// Usage: requests of four points (line one through a_start/a_end, line two
// through b_start/b_end) enter on pts; the intersection point leaves on
// isect, one result per request, in order. Coordinates are signed fixed point.
// cfg_wr_en/cfg_wr_data write the parallel tolerance; write it only while idle.
// Throughput: one request per cycle while isect does not stall. The pipeline has
// five front stages, one restoring-division stage per quotient bit
// (2*COORD_WIDTH+35 bits), five back stages and the output register.
// The division chain sets the latency.
// Reset (rst, synchronous) empties the pipeline and sets the tolerance to 1.
// When isect stalls, the result holds in the output register; the pipeline
// keeps advancing while its last stage is empty, then holds all stages.
module line_intersection_2d #(
  parameter int COORD_WIDTH = lid_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lid_pkg::TOL_WIDTH-1:0] cfg_wr_data,
  lid_pts_if.sink                       pts,
  lid_isect_if.source                   isect
);

  localparam int DW     = COORD_WIDTH + 1;
  localparam int MW     = 2 * DW + 1;
  localparam int NW     = MW + lid_pkg::UA_FRAC;
  localparam int SIDE_W = 1 + 2 * DW + 2 * COORD_WIDTH;

  logic [lid_pkg::TOL_WIDTH-1:0] tol;
  logic                          en;

  logic                          f_v, f_qneg;
  logic [MW-1:0]                 f_d;
  logic [NW-1:0]                 f_n;
  logic signed [DW-1:0]          f_dax, f_day;
  logic signed [COORD_WIDTH-1:0] f_ax0, f_ay0;

  logic              dv   [NW+1];
  logic [MW-1:0]     drem [NW+1];
  logic [NW-1:0]     dnq  [NW+1];
  logic [MW-1:0]     dd   [NW+1];
  logic [SIDE_W-1:0] dside[NW+1];

  logic                          b_v;
  logic signed [COORD_WIDTH-1:0] b_cx, b_cy;
  logic                          ov;
  logic signed [COORD_WIDTH-1:0] ocx, ocy;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= lid_pkg::TOL_WIDTH'(1);
    end else if (cfg_wr_en) begin
      tol <= cfg_wr_data;
    end
  end

  assign en        = !b_v || !ov || isect.ready;
  assign pts.ready = en;

  lid_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .tol      (tol),
    .in_valid (pts.valid),
    .ax0      (pts.a_start_x),
    .ay0      (pts.a_start_y),
    .ax1      (pts.a_end_x),
    .ay1      (pts.a_end_y),
    .bx0      (pts.b_start_x),
    .by0      (pts.b_start_y),
    .bx1      (pts.b_end_x),
    .by1      (pts.b_end_y),
    .out_valid(f_v),
    .d_mag    (f_d),
    .dividend (f_n),
    .q_neg    (f_qneg),
    .o_dax    (f_dax),
    .o_day    (f_day),
    .o_ax0    (f_ax0),
    .o_ay0    (f_ay0)
  );

  assign dv[0]    = f_v;
  assign drem[0]  = '0;
  assign dnq[0]   = f_n;
  assign dd[0]    = f_d;
  assign dside[0] = {f_qneg, f_dax, f_day, f_ax0, f_ay0};

  for (genvar i = 0; i < NW; i++) begin : g_div
    lid_div_stage #(.MW(MW), .NW(NW), .SIDE_W(SIDE_W)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv[i]),
      .in_rem   (drem[i]),
      .in_nq    (dnq[i]),
      .in_d     (dd[i]),
      .in_side  (dside[i]),
      .out_valid(dv[i+1]),
      .out_rem  (drem[i+1]),
      .out_nq   (dnq[i+1]),
      .out_d    (dd[i+1]),
      .out_side (dside[i+1])
    );
  end

  lid_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (dv[NW]),
    .ua       (dnq[NW]),
    .q_neg    (dside[NW][SIDE_W-1]),
    .dax      (dside[NW][SIDE_W-2 -: DW]),
    .day      (dside[NW][SIDE_W-2-DW -: DW]),
    .ax0      (dside[NW][2*COORD_WIDTH-1:COORD_WIDTH]),
    .ay0      (dside[NW][COORD_WIDTH-1:0]),
    .out_valid(b_v),
    .cx       (b_cx),
    .cy       (b_cy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en && b_v) begin
      ov <= 1'b1;
    end else if (isect.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && b_v) begin
      ocx <= b_cx;
      ocy <= b_cy;
    end
  end

  assign isect.valid   = ov;
  assign isect.cross_x = ocx;
  assign isect.cross_y = ocy;

  a_div_rem_below_d: assert property (@(posedge clk) disable iff (rst)
    dv[NW] |-> (drem[NW] < dd[NW]))
    else $error("division remainder not below divisor");

  a_divisor_clamped: assert property (@(posedge clk) disable iff (rst)
    f_v |-> ((f_d >= MW'(tol)) && (f_d != '0)))
    else $error("divisor below tolerance");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (ov && !isect.ready && b_v) |=> (ov && $stable(ocx) && $stable(ocy) && b_v))
    else $error("pipeline advanced into a stalled output");

endmodule
